### hdl/tcu_pkg.sv
package tcu_pkg;

  // Field widths of the stream payload.
  localparam int COORD_W    = 16;
  localparam int TILE_IDX_W = 8;
  localparam int COLOR_W    = 8;
  localparam int CANVAS_W   = 12;
  localparam int MASK_DIM   = 8;
  localparam int MASK_W     = MASK_DIM * MASK_DIM;
  localparam int CLASS_W    = 2;
  localparam int CFG_IDX_W  = 1;

  // Internal arithmetic widths.
  // Edge deltas are one bit wider than a coordinate.
  localparam int DELTA_W = COORD_W + 1;
  // A vertex rounded up to whole pixels, signed.
  localparam int PIX_W   = COORD_W - 3;
  // Block origin in pixels, sized for the largest block edge of eight.
  localparam int MAX_TILE_SIZE = 8;
  localparam int PIXEL_W = $clog2(((1 << TILE_IDX_W) - 1) * MAX_TILE_SIZE + 1);
  // Product of a delta and a coordinate.
  localparam int PROD_W  = DELTA_W + COORD_W;
  // Edge function values, with headroom over the largest sum of products.
  localparam int E_W     = PROD_W + 5;

  // Defaults.
  localparam int DEF_TILE_SIZE     = 8;
  localparam int DEF_CANVAS_WIDTH  = 640;
  localparam int DEF_CANVAS_HEIGHT = 480;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

  // Block class codes.
  typedef enum logic [CLASS_W-1:0] {
    CLASS_OUTSIDE = 2'd0,
    CLASS_REJECT  = 2'd1,
    CLASS_PARTIAL = 2'd2,
    CLASS_FULL    = 2'd3
  } tile_class_t;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_load_t;

  // Stage 1 payload: vertices, edge deltas, rounded vertices, block origin.
  typedef struct packed {
    logic [2:0][COORD_W-1:0] x;
    logic [2:0][COORD_W-1:0] y;
    logic [2:0][DELTA_W-1:0] dx;
    logic [2:0][DELTA_W-1:0] dy;
    logic [2:0][PIX_W-1:0]   ceil_x;
    logic [2:0][PIX_W-1:0]   ceil_y;
    logic [PIXEL_W-1:0]      tx;
    logic [PIXEL_W-1:0]      ty;
    logic [COLOR_W-1:0]      color;
  } setup_t;

  // Stage 3 payload: edge values at the block origin.
  typedef struct packed {
    logic [2:0][E_W-1:0]     e0;
    logic [2:0][DELTA_W-1:0] dx;
    logic [2:0][DELTA_W-1:0] dy;
    logic                    in_box;
    logic [PIXEL_W-1:0]      tx;
    logic [PIXEL_W-1:0]      ty;
    logic [COLOR_W-1:0]      color;
  } edge_t;

  // Rounds a 12.4 coordinate up to whole pixels, floor((v + 15) / 16).
  function automatic logic [PIX_W-1:0] pix_ceil(input logic [COORD_W-1:0] v);
    logic signed [COORD_W:0] sum;
    sum = $signed({v[COORD_W-1], v}) + (COORD_W+1)'(15);
    return sum[COORD_W:4];
  endfunction

endpackage

### hdl/triangle_tile_coverage_unit.sv
// Throughput: one block test per cycle while m_tready holds; the five stage
// registers each hold one beat, and any stage holding a bubble still takes a new beat under stall.
// Reset (rst, synchronous, active high) empties the pipeline and sets the
// canvas to 640 x 480 pixels.
module triangle_tile_coverage_unit import tcu_pkg::*; #(
  parameter int TILE_SIZE = DEF_TILE_SIZE
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CANVAS_W-1:0]  cfg_data,
  // Input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // ax, ay, bx, by_coord, cx, cy, tile_col, tile_row, fill_color
  input  logic [119:0]         s_tdata,
  // Output stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // coverage_mask, out_color
  output logic [71:0]          m_tdata,
  // tile_class
  output logic [CLASS_W-1:0]   m_tuser
);

  logic [CANVAS_W-1:0] canvas_width;
  logic [CANVAS_W-1:0] canvas_height;
  logic [5:1]          vld;
  logic [5:1]          rdy;
  stage_load_t         load;
  setup_t              s1;
  edge_t               s3;
  logic [MASK_W-1:0]   coverage_mask;
  tile_class_t         tile_class;
  logic [COLOR_W-1:0]  out_color;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CANVAS_W'(DEF_CANVAS_WIDTH);
      canvas_height <= CANVAS_W'(DEF_CANVAS_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage takes a new beat when it is empty or its beat moves on.
  always_comb begin
    rdy[5] = !vld[5] || m_tready;
    rdy[4] = !vld[4] || rdy[5];
    rdy[3] = !vld[3] || rdy[4];
    rdy[2] = !vld[2] || rdy[3];
    rdy[1] = !vld[1] || rdy[2];
  end

  // No input beat is taken while reset is held.
  assign load = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4], s5: rdy[5]};
  assign s_tready = rdy[1] && !rst;
  assign m_tvalid = vld[5];

  // Valid bits travel with the stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= s_tvalid;
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
      if (rdy[4]) vld[4] <= vld[3];
      if (rdy[5]) vld[5] <= vld[4];
    end
  end

  tcu_setup #(.TILE_SIZE(TILE_SIZE)) u_setup (
    .clk        (clk),
    .load       (load),
    .ax         (s_tdata[15:0]),
    .ay         (s_tdata[31:16]),
    .bx         (s_tdata[47:32]),
    .by_coord   (s_tdata[63:48]),
    .cx         (s_tdata[79:64]),
    .cy         (s_tdata[95:80]),
    .tile_col   (s_tdata[103:96]),
    .tile_row   (s_tdata[111:104]),
    .fill_color (s_tdata[119:112]),
    .s1         (s1)
  );

  tcu_edge #(.TILE_SIZE(TILE_SIZE)) u_edge (
    .clk           (clk),
    .load          (load),
    .canvas_width  (canvas_width),
    .canvas_height (canvas_height),
    .s1            (s1),
    .s3            (s3)
  );

  tcu_block #(.TILE_SIZE(TILE_SIZE)) u_block (
    .clk           (clk),
    .load          (load),
    .canvas_width  (canvas_width),
    .canvas_height (canvas_height),
    .s3            (s3),
    .coverage_mask (coverage_mask),
    .tile_class    (tile_class),
    .out_color     (out_color)
  );

  assign m_tdata = {out_color, coverage_mask};
  assign m_tuser = tile_class;

endmodule

### hdl/tcu_setup.sv
module tcu_setup import tcu_pkg::*; #(
  parameter int TILE_SIZE = DEF_TILE_SIZE
) (
  input  logic                  clk,
  input  stage_load_t           load,
  input  logic [COORD_W-1:0]    ax,
  input  logic [COORD_W-1:0]    ay,
  input  logic [COORD_W-1:0]    bx,
  input  logic [COORD_W-1:0]    by_coord,
  input  logic [COORD_W-1:0]    cx,
  input  logic [COORD_W-1:0]    cy,
  input  logic [TILE_IDX_W-1:0] tile_col,
  input  logic [TILE_IDX_W-1:0] tile_row,
  input  logic [COLOR_W-1:0]    fill_color,
  output setup_t                s1
);

  logic [2:0][COORD_W-1:0] vx;
  logic [2:0][COORD_W-1:0] vy;
  setup_t                  s1_next;

  assign vx = {cx, bx, ax};
  assign vy = {cy, by_coord, ay};

  // Edge deltas, rounded vertices and the block origin in pixels.
  always_comb begin
    int j;
    s1_next = '0;
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      s1_next.x[i]  = vx[i];
      s1_next.y[i]  = vy[i];
      s1_next.dx[i] = DELTA_W'($signed(vx[i])) - DELTA_W'($signed(vx[j]));
      s1_next.dy[i] = DELTA_W'($signed(vy[i])) - DELTA_W'($signed(vy[j]));
      s1_next.ceil_x[i] = pix_ceil(vx[i]);
      s1_next.ceil_y[i] = pix_ceil(vy[i]);
    end
    s1_next.tx    = PIXEL_W'(32'(tile_col) * TILE_SIZE);
    s1_next.ty    = PIXEL_W'(32'(tile_row) * TILE_SIZE);
    s1_next.color = fill_color;
  end

  always_ff @(posedge clk) begin
    if (load.s1) begin
      s1 <= s1_next;
    end
  end

endmodule

### hdl/tcu_edge.sv
module tcu_edge import tcu_pkg::*; #(
  parameter int TILE_SIZE = DEF_TILE_SIZE
) (
  input  logic                clk,
  input  stage_load_t         load,
  input  logic [CANVAS_W-1:0] canvas_width,
  input  logic [CANVAS_W-1:0] canvas_height,
  input  setup_t              s1,
  output edge_t               s3
);

  typedef struct packed {
    logic [CANVAS_W-1:0] lo;
    logic [CANVAS_W-1:0] hi;
  } span_t;

  // Stage 2 registers.
  logic signed [PROD_W-1:0] p_dyx [3];
  logic signed [PROD_W-1:0] p_dxy [3];
  logic signed [PROD_W-1:0] p_dxt [3];
  logic signed [PROD_W-1:0] p_dyt [3];
  logic [2:0]               bias;
  logic                     in_box;
  logic [2:0][DELTA_W-1:0]  dx;
  logic [2:0][DELTA_W-1:0]  dy;
  logic [PIXEL_W-1:0]       tx;
  logic [PIXEL_W-1:0]       ty;
  logic [COLOR_W-1:0]       color;

  logic signed [COORD_W-1:0] tx16;
  logic signed [COORD_W-1:0] ty16;
  span_t                     span_x;
  span_t                     span_y;
  logic                      in_box_next;
  edge_t                     s3_next;

  // Min and max of three rounded coordinates, clamped to [0, lim].
  function automatic span_t clamp_span(input logic [2:0][PIX_W-1:0] c,
                                       input logic [CANVAS_W-1:0] lim);
    logic signed [PIX_W-1:0] mn;
    logic signed [PIX_W-1:0] mx;
    logic signed [PIX_W-1:0] top;
    span_t                   s;
    mn  = $signed(c[0]);
    mx  = $signed(c[0]);
    top = $signed({1'b0, lim});
    for (int i = 1; i < 3; i++) begin
      if ($signed(c[i]) < mn) mn = $signed(c[i]);
      if ($signed(c[i]) > mx) mx = $signed(c[i]);
    end
    s.lo = (mn < 0) ? '0 : ((mn > top) ? lim : CANVAS_W'(mn));
    s.hi = (mx < 0) ? '0 : ((mx > top) ? lim : CANVAS_W'(mx));
    return s;
  endfunction

  assign tx16 = $signed({1'b0, s1.tx, 4'b0000});
  assign ty16 = $signed({1'b0, s1.ty, 4'b0000});

  // Bounding box test. The box minimum is rounded down to a block edge;
  // since the block origin is itself a block multiple, origin + size > min
  // gives the same answer.
  always_comb begin
    span_x = clamp_span(s1.ceil_x, canvas_width);
    span_y = clamp_span(s1.ceil_y, canvas_height);
    in_box_next =
      ((CANVAS_W+1)'(s1.tx) + (CANVAS_W+1)'(TILE_SIZE) > (CANVAS_W+1)'(span_x.lo)) &&
      ((CANVAS_W+1)'(s1.tx) < (CANVAS_W+1)'(span_x.hi)) &&
      ((CANVAS_W+1)'(s1.ty) + (CANVAS_W+1)'(TILE_SIZE) > (CANVAS_W+1)'(span_y.lo)) &&
      ((CANVAS_W+1)'(s1.ty) < (CANVAS_W+1)'(span_y.hi));
  end

  // Stage 2: edge products and the top-left fill bias.
  always_ff @(posedge clk) begin
    if (load.s2) begin
      for (int i = 0; i < 3; i++) begin
        p_dyx[i] <= $signed(s1.dy[i]) * $signed(s1.x[i]);
        p_dxy[i] <= $signed(s1.dx[i]) * $signed(s1.y[i]);
        p_dxt[i] <= $signed(s1.dx[i]) * ty16;
        p_dyt[i] <= $signed(s1.dy[i]) * tx16;
        bias[i]  <= $signed(s1.dy[i]) < 0 ||
                    ($signed(s1.dy[i]) == 0 && $signed(s1.dx[i]) > 0);
      end
      in_box <= in_box_next;
      dx     <= s1.dx;
      dy     <= s1.dy;
      tx     <= s1.tx;
      ty     <= s1.ty;
      color  <= s1.color;
    end
  end

  // Edge constant plus the step to the block origin.
  always_comb begin
    s3_next = '0;
    for (int i = 0; i < 3; i++) begin
      s3_next.e0[i] = E_W'(p_dyx[i]) - E_W'(p_dxy[i]) + E_W'(bias[i]) +
                      E_W'(p_dxt[i]) - E_W'(p_dyt[i]);
    end
    s3_next.dx     = dx;
    s3_next.dy     = dy;
    s3_next.in_box = in_box;
    s3_next.tx     = tx;
    s3_next.ty     = ty;
    s3_next.color  = color;
  end

  // Stage 3 register.
  always_ff @(posedge clk) begin
    if (load.s3) begin
      s3 <= s3_next;
    end
  end

endmodule

### hdl/tcu_block.sv
module tcu_block import tcu_pkg::*; #(
  parameter int TILE_SIZE = DEF_TILE_SIZE
) (
  input  logic                clk,
  input  stage_load_t         load,
  input  logic [CANVAS_W-1:0] canvas_width,
  input  logic [CANVAS_W-1:0] canvas_height,
  input  edge_t               s3,
  output logic [MASK_W-1:0]   coverage_mask,
  output tile_class_t         tile_class,
  output logic [COLOR_W-1:0]  out_color
);

  // Stage 4 registers.
  logic signed [E_W-1:0] row_base [3][MASK_DIM];
  logic signed [E_W-1:0] col_step [3][MASK_DIM];
  logic [MASK_DIM-1:0]   col_ok;
  logic [MASK_DIM-1:0]   row_ok;
  logic                  reject;
  logic                  full;
  logic                  in_box;
  logic [COLOR_W-1:0]    color;

  logic signed [E_W-1:0] row_base_next [3][MASK_DIM];
  logic signed [E_W-1:0] col_step_next [3][MASK_DIM];
  logic [MASK_DIM-1:0]   col_ok_next;
  logic [MASK_DIM-1:0]   row_ok_next;
  logic                  reject_next;
  logic                  full_next;
  logic [MASK_W-1:0]     mask_next;
  tile_class_t           class_next;

  // Corner tests for the whole block, per-row edge values, per-column
  // steps and the canvas limits.
  always_comb begin
    logic signed [E_W-1:0] fdx;
    logic signed [E_W-1:0] fdy;
    logic signed [E_W-1:0] eo;
    logic signed [E_W-1:0] ei;
    logic signed [E_W-1:0] e0;
    reject_next = 1'b0;
    full_next   = 1'b1;
    for (int i = 0; i < 3; i++) begin
      fdx = E_W'($signed(s3.dx[i])) <<< 4;
      fdy = E_W'($signed(s3.dy[i])) <<< 4;
      e0  = $signed(s3.e0[i]);
      eo  = ((fdy < 0) ? -fdy : E_W'(0)) + ((fdx > 0) ? fdx : E_W'(0));
      eo  = eo * E_W'(TILE_SIZE);
      ei  = (fdx - fdy) * E_W'(TILE_SIZE) - eo;
      if (e0 + eo < 0) reject_next = 1'b1;
      if (!(e0 + ei > 0)) full_next = 1'b0;
      for (int k = 0; k < MASK_DIM; k++) begin
        row_base_next[i][k] = e0 + fdx * E_W'(k);
        col_step_next[i][k] = fdy * E_W'(k);
      end
    end
    for (int k = 0; k < MASK_DIM; k++) begin
      col_ok_next[k] = (k < TILE_SIZE) &&
        ((CANVAS_W+1)'(s3.tx) + (CANVAS_W+1)'(k) < (CANVAS_W+1)'(canvas_width));
      row_ok_next[k] = (k < TILE_SIZE) &&
        ((CANVAS_W+1)'(s3.ty) + (CANVAS_W+1)'(k) < (CANVAS_W+1)'(canvas_height));
    end
  end

  always_ff @(posedge clk) begin
    if (load.s4) begin
      row_base <= row_base_next;
      col_step <= col_step_next;
      col_ok   <= col_ok_next;
      row_ok   <= row_ok_next;
      reject   <= reject_next;
      full     <= full_next;
      in_box   <= s3.in_box;
      color    <= s3.color;
    end
  end

  // Per-pixel edge tests, canvas masking and the block class.
  always_comb begin
    logic in_tri;
    mask_next = '0;
    for (int r = 0; r < MASK_DIM; r++) begin
      for (int c = 0; c < MASK_DIM; c++) begin
        in_tri = 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (!(row_base[i][r] - col_step[i][c] > 0)) in_tri = 1'b0;
        end
        mask_next[r*MASK_DIM+c] = (full || in_tri) && col_ok[c] && row_ok[r];
      end
    end
    if (!in_box) begin
      class_next = CLASS_OUTSIDE;
      mask_next  = '0;
    end else if (reject) begin
      class_next = CLASS_REJECT;
      mask_next  = '0;
    end else if (full) begin
      class_next = CLASS_FULL;
    end else begin
      class_next = CLASS_PARTIAL;
    end
  end

  // Stage 5 is the output register.
  always_ff @(posedge clk) begin
    if (load.s5) begin
      coverage_mask <= mask_next;
      tile_class    <= class_next;
      out_color     <= color;
    end
  end

endmodule
